/* hw/rtl/itsg_pkg.sv */
// ----------------------------------------------------------------------------
// itsg_pkg
// Shared types and constants for the transport frame segmenter.
// ----------------------------------------------------------------------------
package itsg_pkg;

	localparam int unsigned SF_MAX  = 7;   // payload bytes in a single frame
	localparam int unsigned FF_DATA = 6;   // payload bytes in a first frame
	localparam int unsigned CF_DATA = 7;   // payload bytes in a consecutive frame

	localparam logic [3:0] PCI_SINGLE = 4'h0;
	localparam logic [3:0] PCI_FIRST  = 4'h1;
	localparam logic [3:0] PCI_CONSEC = 4'h2;

	typedef enum logic [1:0] {
		KIND_SINGLE = 2'd0,
		KIND_FIRST  = 2'd1,
		KIND_CONSEC = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [11:0] msg_length;
	} item_t;

	typedef struct packed {
		logic [10:0] can_id;
		logic [63:0] frame_bytes;
		kind_t       frame_kind;
		logic        last_frame;
	} frame_t;

	// handshake from the framer to the input and output registers
	typedef struct packed {
		logic step;   // s1 item is consumed this cycle
		logic load;   // a frame goes into the output register
	} step_ctl_t;

endpackage

/* hw/rtl/itsg_in_reg.sv */
// ----------------------------------------------------------------------------
// itsg_in_reg
// Input register stage: holds one accepted byte until the framer consumes it.
// ----------------------------------------------------------------------------
module itsg_in_reg
	import itsg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t item,
	input  logic  step,
	output logic  valid_s1,
	output item_t item_s1
);

	logic take;

	assign in_ready = !valid_s1 || step;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

endmodule

/* hw/rtl/itsg_framer.sv */
// ----------------------------------------------------------------------------
// itsg_framer
// Message state and frame assembly: one byte per step, builds the PCI and
// the padded payload of a frame when it closes.
// ----------------------------------------------------------------------------
module itsg_framer
	import itsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  item_t       item_s1,
	input  logic        out_free,
	input  logic [10:0] frame_id,
	output step_ctl_t   ctl,
	output frame_t      frame
);

	logic [11:0] bytes_taken_q;
	logic [2:0]  frame_fill_q;
	logic [55:0] pending_q;
	logic [3:0]  seq_q;

	logic [11:0] len;
	logic        len_zero;
	logic [12:0] n_inc;
	logic [3:0]  c;
	logic [2:0]  c3;
	logic        done;
	logic        emit;
	kind_t       kind;
	logic [55:0] pending_nx;
	logic [63:0] pend64;
	logic [5:0]  sh7;
	logic [5:0]  sh6;
	logic [63:0] body7;
	logic [63:0] body6;
	logic [63:0] bytes_nx;

	assign len        = item_s1.msg_length;
	assign len_zero   = (len == 12'd0);
	assign n_inc      = {1'b0, bytes_taken_q} + 13'd1;
	assign c          = {1'b0, frame_fill_q} + 4'd1;
	assign c3         = (c > 4'(CF_DATA)) ? 3'(CF_DATA) : c[2:0];
	assign done       = (n_inc >= {1'b0, len});
	assign pending_nx = {pending_q[47:0], item_s1.data_byte};
	assign pend64     = {8'h00, pending_nx};

	always_comb begin
		if (len <= 12'(SF_MAX)) begin
			kind = KIND_SINGLE;
			emit = done || (c >= 4'(SF_MAX));
		end else if (bytes_taken_q < 12'(FF_DATA)) begin
			kind = KIND_FIRST;
			emit = done || (c >= 4'(FF_DATA)) || (n_inc >= 13'(FF_DATA));
		end else begin
			kind = KIND_CONSEC;
			emit = done || (c >= 4'(CF_DATA));
		end
	end

	// left-align the held bytes right after the pci bytes
	assign sh7   = {3'(CF_DATA) - c3, 3'b000};
	assign sh6   = (c3 <= 3'(FF_DATA)) ? {3'(FF_DATA) - c3, 3'b000} : 6'd0;
	assign body7 = pend64 << sh7;
	assign body6 = pend64 << sh6;

	always_comb begin
		case (kind)
			KIND_SINGLE: bytes_nx = {PCI_SINGLE, 1'b0, c3, 56'd0} | body7;
			KIND_FIRST:  bytes_nx = {PCI_FIRST, len, 48'd0} | {16'd0, body6[47:0]};
			KIND_CONSEC: bytes_nx = {PCI_CONSEC, seq_q, 56'd0} | body7;
			default:     bytes_nx = 64'd0;
		endcase
	end

	assign ctl.step = valid_s1 && (!emit || out_free || len_zero);
	assign ctl.load = ctl.step && emit && !len_zero;

	assign frame.can_id      = frame_id;
	assign frame.frame_bytes = bytes_nx;
	assign frame.frame_kind  = kind;
	assign frame.last_frame  = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_taken_q <= 12'd0;
			frame_fill_q  <= 3'd0;
			pending_q     <= 56'd0;
			seq_q         <= 4'd1;
		end else if (ctl.step && !len_zero) begin
			if (!emit) begin
				frame_fill_q  <= c3;
				bytes_taken_q <= n_inc[11:0];
				pending_q     <= pending_nx;
			end else if (done) begin
				bytes_taken_q <= 12'd0;
				frame_fill_q  <= 3'd0;
				pending_q     <= 56'd0;
				seq_q         <= 4'd1;
			end else begin
				seq_q         <= (kind == KIND_CONSEC) ? seq_q + 4'd1 : 4'd1;
				frame_fill_q  <= 3'd0;
				pending_q     <= 56'd0;
				bytes_taken_q <= n_inc[11:0];
			end
		end
	end

endmodule

/* hw/rtl/itsg_out_reg.sv */
// ----------------------------------------------------------------------------
// itsg_out_reg
// Result register: holds a finished frame until the sink takes the word.
// ----------------------------------------------------------------------------
module itsg_out_reg
	import itsg_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  frame_t frame,
	input  logic   out_ready,
	output logic   out_valid,
	output logic   out_free,
	output frame_t frame_q
);

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame;
		end
	end

endmodule

/* hw/rtl/isotp_transmit_segmenter.sv */
// ----------------------------------------------------------------------------
// isotp_transmit_segmenter
// Cuts a byte stream into single, first and consecutive transport frames.
// ----------------------------------------------------------------------------
// a byte that closes a frame passes the input register, then the output register
// throughput: one byte per cycle when not stalled, set by the single framer step per byte
// a waiting frame stalls the input only once the next closing byte reaches the framer
// reset: async active low, clears message state, sequence number to 1, id to 0
module isotp_transmit_segmenter
	import itsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [11:0] msg_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] can_id,
	output logic [63:0] frame_bytes,
	output logic [1:0]  frame_kind,
	output logic        last_frame
);

	logic [10:0] frame_id_q;
	item_t       item;
	item_t       item_s1;
	logic        valid_s1;
	logic        out_free;
	step_ctl_t   ctl;
	frame_t      frame;
	frame_t      frame_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_id_q <= 11'd0;
		end else if (cfg_valid && cfg_ready) begin
			frame_id_q <= cfg_data;
		end
	end

	assign item.data_byte  = data_byte;
	assign item.msg_length = msg_length;

	itsg_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.step     (ctl.step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	itsg_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.frame_id (frame_id_q),
		.ctl      (ctl),
		.frame    (frame)
	);

	itsg_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (ctl.load),
		.frame     (frame),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_free  (out_free),
		.frame_q   (frame_q)
	);

	assign can_id      = frame_q.can_id;
	assign frame_bytes = frame_q.frame_bytes;
	assign frame_kind  = frame_q.frame_kind;
	assign last_frame  = frame_q.last_frame;

	// a waiting frame is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> (!out_valid || out_ready))
		else $error("frame loaded over a word not yet taken");

	// a single frame always ends its message
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_kind == KIND_SINGLE) |-> last_frame)
		else $error("single frame without last_frame");

	// pci nibble agrees with the frame kind
	a_pci_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((frame_kind == KIND_SINGLE && frame_bytes[63:60] == PCI_SINGLE) ||
			(frame_kind == KIND_FIRST && frame_bytes[63:60] == PCI_FIRST) ||
			(frame_kind == KIND_CONSEC && frame_bytes[63:60] == PCI_CONSEC)))
		else $error("pci type does not match frame_kind");

	// a single frame carries between one and seven bytes
	a_single_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_kind == KIND_SINGLE) |->
			(frame_bytes[59:56] != 4'd0 && frame_bytes[59] == 1'b0))
		else $error("single frame length out of range");

endmodule
